// File: design/ftfr_pkg.sv
`timescale 1ns / 1ps
package ftfr_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REWIND = 2'd2,
    MODE_COMMIT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned FIELD_W     = 9;
  // frame counter keeps full width so that the saturating decrement is exact
  localparam int unsigned FRAME_CNT_W = 32;

  typedef struct packed {
    logic                pop_ok;
    status_t             status;
    logic [FIELD_W-1:0]  frames;
    logic [FIELD_W-1:0]  bytes;
  } op_result_t;

endpackage

// File: design/ftfr_if.sv
`timescale 1ns / 1ps
interface ftfr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_in;

  modport source (output valid, output mode, output data_in, input ready);
  modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface ftfr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       frame_end;
  logic [1:0] status;
  logic [8:0] frames_waiting;
  logic [8:0] bytes_stored;

  modport source (output valid, output data_out, output frame_end, output status,
                  output frames_waiting, output bytes_stored, input ready);
  modport sink   (input valid, input data_out, input frame_end, input status,
                  input frames_waiting, input bytes_stored, output ready);
endinterface

// File: design/ftfr_ram.sv
`timescale 1ns / 1ps
module ftfr_ram
  import ftfr_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ftfr_ctrl.sv
`timescale 1ns / 1ps
module ftfr_ctrl
  import ftfr_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned CW    = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        mode,
  input  logic [DATA_W-1:0] data_in,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic              re,
  output logic [AW-1:0]     raddr,
  output op_result_t        result
);

  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0]          write_pointer, write_pointer_next;
  logic [AW-1:0]          read_pointer, read_pointer_next;
  logic [AW-1:0]          mark_pointer, mark_pointer_next;
  logic [CW-1:0]          stored_count, stored_count_next;
  logic [CW-1:0]          pending_count, pending_count_next;
  logic [FRAME_CNT_W-1:0] frame_count, frame_count_next;
  logic [CW-1:0]          released;
  logic [31:0]            stored_wide;
  logic                   pop_ok;
  status_t                status;

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    mark_pointer_next  = mark_pointer;
    stored_count_next  = stored_count;
    pending_count_next = pending_count;
    frame_count_next   = frame_count;
    released           = pending_count;
    we                 = 1'b0;
    re                 = 1'b0;
    pop_ok             = 1'b0;
    status             = STATUS_OK;
    unique case (mode_t'(mode))
      MODE_PUSH: begin
        if (stored_count == FULL_CNT) begin
          status = STATUS_FULL;
        end else begin
          we                 = accept;
          write_pointer_next = (write_pointer == LAST_POS) ? '0 : write_pointer + 1'b1;
          stored_count_next  = stored_count + 1'b1;
          if (data_in == '0) begin
            frame_count_next = frame_count + 1'b1;
          end
        end
      end
      MODE_POP: begin
        if (pending_count >= stored_count) begin
          status = STATUS_EMPTY;
        end else begin
          re                 = accept;
          pop_ok             = 1'b1;
          read_pointer_next  = (read_pointer == LAST_POS) ? '0 : read_pointer + 1'b1;
          pending_count_next = pending_count + 1'b1;
        end
      end
      MODE_REWIND: begin
        read_pointer_next  = mark_pointer;
        pending_count_next = '0;
      end
      MODE_COMMIT: begin
        if (pending_count > stored_count) begin
          released = stored_count;
        end
        stored_count_next  = stored_count - released;
        mark_pointer_next  = read_pointer;
        pending_count_next = '0;
        if (frame_count != '0) begin
          frame_count_next = frame_count - 1'b1;
        end
        // buffer drained: align every pointer to the write position
        if (stored_count_next == '0) begin
          read_pointer_next = write_pointer;
          mark_pointer_next = write_pointer;
          frame_count_next  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign waddr = write_pointer;
  assign raddr = read_pointer;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      mark_pointer  <= '0;
      stored_count  <= '0;
      pending_count <= '0;
      frame_count   <= '0;
    end else if (accept) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      mark_pointer  <= mark_pointer_next;
      stored_count  <= stored_count_next;
      pending_count <= pending_count_next;
      frame_count   <= frame_count_next;
    end
  end

  assign stored_wide   = 32'(stored_count_next);
  assign result.pop_ok = pop_ok;
  assign result.status = status;
  assign result.frames = frame_count_next[FIELD_W-1:0];
  assign result.bytes  = stored_wide[FIELD_W-1:0];

endmodule

// File: design/framed_tx_fifo_with_rewind.sv
`timescale 1ns / 1ps
// Path: an accepted request beat is registered in stage 1 together with the byte
// store read, then in the output register; stage 1 holds while the output stalls.
// Throughput: one request beat per cycle unless the output stalls; pointers update
// per accepted beat and the single write and read port of the byte store serve each
// beat once. Reset: synchronous, active high; clears pointers, counters and both stages.
// The byte store is not cleared; only written entries are ever read.
module framed_tx_fifo_with_rewind
  import ftfr_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  ftfr_req_if.sink   req,
  ftfr_rsp_if.source rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              accept;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] rdata;
  op_result_t        result;

  logic              s1_valid;
  op_result_t        s1_result;
  logic              s1_advance;

  assign s1_advance = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign accept     = req.valid && req.ready;

  ftfr_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .mode    (req.mode),
    .data_in (req.data_in),
    .we      (we),
    .waddr   (waddr),
    .re      (re),
    .raddr   (raddr),
    .result  (result)
  );

  ftfr_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.data_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // stage 1 waits for the read word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_result <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp.data_out       <= s1_result.pop_ok ? rdata : '0;
      rsp.frame_end      <= s1_result.pop_ok && (rdata == '0);
      rsp.status         <= s1_result.status;
      rsp.frames_waiting <= s1_result.frames;
      rsp.bytes_stored   <= s1_result.bytes;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat did not reach stage 1");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_result)))
    else $error("stalled stage 1 lost its beat");

  a_no_data_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STATUS_OK)) |-> (rsp.data_out == '0 && !rsp.frame_end))
    else $error("failed operation returned data");

  a_frame_end_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.frame_end) |-> (rsp.data_out == '0 && rsp.status == STATUS_OK))
    else $error("frame end flagged on non-terminator");

endmodule

// File: test/framed_tx_fifo_with_rewind_tb.sv
`timescale 1ns / 1ps
module framed_tx_fifo_with_rewind_tb;
  import ftfr_pkg::*;

  localparam int unsigned FIFO_DEPTH     = 256;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS    = 510;

  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] data;
  } tx_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               frame_end;
    status_t            status;
    logic [FIELD_W-1:0] frames;
    logic [FIELD_W-1:0] bytes;
  } tx_rsp_t;

  logic clk = 1'b0;
  logic rst;

  ftfr_req_if req_ch ();
  ftfr_rsp_if rsp_ch ();

  framed_tx_fifo_with_rewind #(
    .DEPTH(FIFO_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #6 clk = ~clk;

  tx_op_t      op_q[$];
  tx_rsp_t     expected_rsp_q[$];
  int unsigned frame_len_q[$];
  int unsigned queued_items;
  int unsigned mismatches;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          long_hold_req;
  bit          long_hold_taken;

  // ring buffer shadow
  logic [DATA_W-1:0] ring_mem [FIFO_DEPTH];
  int unsigned       wr_pos;
  int unsigned       rd_pos;
  int unsigned       mark_pos;
  int unsigned       held_bytes;
  int unsigned       read_ahead;
  int unsigned       frame_total;

  function automatic tx_rsp_t predict_tx_rsp(mode_t op, logic [DATA_W-1:0] byte_in);
    tx_rsp_t r;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      MODE_PUSH: begin
        if (held_bytes >= FIFO_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          ring_mem[wr_pos] = byte_in;
          wr_pos = (wr_pos + 1) % FIFO_DEPTH;
          held_bytes++;
          if (byte_in == '0) frame_total++;
        end
      end
      MODE_POP: begin
        if (read_ahead >= held_bytes) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.data = ring_mem[rd_pos];
          rd_pos = (rd_pos + 1) % FIFO_DEPTH;
          read_ahead++;
          r.frame_end = (r.data == '0);
        end
      end
      MODE_REWIND: begin
        rd_pos = mark_pos;
        read_ahead = 0;
      end
      MODE_COMMIT: begin
        if (read_ahead > held_bytes) read_ahead = held_bytes;
        held_bytes -= read_ahead;
        mark_pos = rd_pos;
        read_ahead = 0;
        if (frame_total > 0) frame_total--;
        // an emptied buffer realigns every position to the write side
        if (held_bytes == 0) begin
          rd_pos = wr_pos;
          mark_pos = wr_pos;
          frame_total = 0;
        end
      end
      default: ;
    endcase
    r.frames = frame_total[FIELD_W-1:0];
    r.bytes = held_bytes[FIELD_W-1:0];
    return r;
  endfunction

  function automatic string rsp_text(tx_rsp_t r);
    return $sformatf("data=%02h end=%0b status=%0d frames=%0d bytes=%0d",
                     r.data, r.frame_end, r.status, r.frames, r.bytes);
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    tx_op_t op;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp_q.push_back(predict_tx_rsp(mode_t'(req_ch.mode), req_ch.data_in));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (op_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          op = op_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.mode <= op.mode;
          req_ch.data_in <= op.data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver back-pressure
  always @(posedge clk) begin : watch
    tx_rsp_t want;
    tx_rsp_t got;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
      long_hold_taken <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.data = rsp_ch.data_out;
        got.frame_end = rsp_ch.frame_end;
        got.status = status_t'(rsp_ch.status);
        got.frames = rsp_ch.frames_waiting;
        got.bytes = rsp_ch.bytes_stored;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %s", rsp_text(got));
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.data !== want.data || got.frame_end !== want.frame_end ||
              got.status !== want.status || got.frames !== want.frames ||
              got.bytes !== want.bytes) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: expected %s, got %s", $realtime,
                       rsp_text(want), rsp_text(got));
            end
          end
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken <= 1'b1;
        hold_left <= LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_op(mode_t m, logic [DATA_W-1:0] d);
    op_q.push_back('{mode: m, data: d});
    queued_items++;
  endtask

  // hold the sender until every beat has gone through and been answered
  task automatic wait_for_drain();
    do @(negedge clk);
    while (op_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
  endtask

  task automatic queue_phase(int unsigned target, bit with_fill);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    int unsigned n;
    start = queued_items;
    if (with_fill) begin
      // overfill so that pushes are dropped, then read everything back
      repeat (FIFO_DEPTH + 6) begin
        add_op(MODE_PUSH, ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
      repeat (FIFO_DEPTH + 14) add_op(MODE_POP, 8'($urandom_range(255)));
      add_op(MODE_COMMIT, 8'($urandom_range(255)));
      frame_len_q.delete();
    end
    while (queued_items - start < target) begin
      r = $urandom_range(99);
      if (r < 45) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (len) add_op(MODE_PUSH, 8'($urandom_range(1, 255)));
        add_op(MODE_PUSH, 8'h00);
        frame_len_q.push_back(len);
      end else if (r < 85) begin
        n = (frame_len_q.size() != 0) ? frame_len_q.pop_front() + 1 : $urandom_range(1, 4);
        repeat (n) add_op(MODE_POP, 8'($urandom_range(255)));
        // bus collision: go back to the mark and send the frame again
        if ($urandom_range(99) < 30) begin
          add_op(MODE_REWIND, 8'($urandom_range(255)));
          repeat (n) add_op(MODE_POP, 8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 10) add_op(MODE_POP, 8'($urandom_range(255)));
        if ($urandom_range(99) < 90) add_op(MODE_COMMIT, 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) add_op(mode_t'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_PUSH;
    req_ch.data_in = '0;
    rsp_ch.ready = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    idle_cycles = 0;
    hold_left = 0;
    long_hold_req = 1'b0;
    long_hold_taken = 1'b0;
    queued_items = 0;
    mismatches = 0;
    wr_pos = 0;
    rd_pos = 0;
    mark_pos = 0;
    held_bytes = 0;
    read_ahead = 0;
    frame_total = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty buffer: pop, commit with no frame, rewind
    add_op(MODE_POP, 8'hFF);
    add_op(MODE_COMMIT, 8'h00);
    add_op(MODE_REWIND, 8'hFF);
    add_op(MODE_PUSH, 8'hFF);
    add_op(MODE_PUSH, 8'h01);
    add_op(MODE_PUSH, 8'h80);
    add_op(MODE_PUSH, 8'h00);
    repeat (4) add_op(MODE_POP, 8'h00);
    add_op(MODE_POP, 8'hFF);
    add_op(MODE_REWIND, 8'h00);
    add_op(MODE_POP, 8'h55);
    add_op(MODE_POP, 8'hAA);
    add_op(MODE_COMMIT, 8'hFF);
    add_op(MODE_PUSH, 8'h7F);
    add_op(MODE_COMMIT, 8'h00);
    repeat (3) add_op(MODE_POP, 8'h00);
    add_op(MODE_COMMIT, 8'h00);
    add_op(MODE_PUSH, 8'h00);
    add_op(MODE_POP, 8'hFF);
    add_op(MODE_COMMIT, 8'hFF);
    wait_for_drain();

    tx_idle_pct = 20;
    rx_idle_pct = 60;
    queue_phase(PHASE_ITEMS, 1'b0);
    wait_for_drain();

    tx_idle_pct = 60;
    rx_idle_pct = 20;
    queue_phase(PHASE_ITEMS, 1'b1);
    wait_for_drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_req = 1'b1;
    queue_phase(PHASE_ITEMS, 1'b0);
    wait_for_drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
